>>> hw/rtl/bha_pkg.sv
package bha_pkg;

  localparam int MIN_ORDER_DEF = 5;
  localparam int MAX_ORDER_DEF = 12;
  localparam int ORD_W = 5;
  localparam int SIZE_W = 16;
  localparam int ADDR_W = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_INVALID   = 2'd1,
    STATUS_NO_SPACE  = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WANT,
    ST_A_RD,
    ST_A_CHK,
    ST_A_UP,
    ST_A_SPLIT,
    ST_A_MARK,
    ST_F_RD,
    ST_F_CHK,
    ST_CO_RD,
    ST_CO_CHK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic split;
    logic alloc;
  } node_t;

  typedef struct packed {
    logic node_we;
    logic size_we;
    logic clr_en;
  } store_ctl_t;

endpackage

>>> hw/rtl/bha_node_store.sv
module bha_node_store import bha_pkg::*; #(
  parameter int MIN_ORDER = MIN_ORDER_DEF,
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [MAX_ORDER-MIN_ORDER:0]        rd_addr,
  output node_t                               rd_node,
  output logic [SIZE_W-1:0]                   rd_size,
  input  store_ctl_t                          ctl,
  input  logic [MAX_ORDER-MIN_ORDER:0]        wr_addr,
  input  node_t                               wr_node,
  input  logic [SIZE_W-1:0]                   wr_size,
  input  logic [MAX_ORDER-MIN_ORDER:0]        clr_addr
);

  localparam int LEVELS = MAX_ORDER - MIN_ORDER + 1;
  localparam int NODE_COUNT = (1 << LEVELS) - 1;
  localparam int IDX_W = LEVELS;

  node_t             node_mem [NODE_COUNT];
  logic [SIZE_W-1:0] size_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] valid;
  logic [IDX_W-1:0]  clr_addr_hi;

  assign clr_addr_hi = clr_addr + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctl.clr_en) begin
        valid[clr_addr]    <= 1'b0;
        valid[clr_addr_hi] <= 1'b0;
      end
      if (ctl.node_we) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.node_we) begin
      node_mem[wr_addr] <= wr_node;
    end
    if (ctl.size_we) begin
      size_mem[wr_addr] <= wr_size;
    end
  end

  // invalid entries read as a free leaf
  always_ff @(posedge clk) begin
    rd_node <= valid[rd_addr] ? node_mem[rd_addr] : '0;
    rd_size <= size_mem[rd_addr];
  end

endmodule

>>> hw/rtl/buddy_heap_allocator_core.sv
// allocate: accepts the word, steps through sizing, reads and checks each tree node visited,
//   backtracks, splits level by level, marks the block and loads the result
// free: accepts the word, reads and checks each level descended and each level merged, then loads
// throughput: one word at a time; the next word is taken the cycle after the result is loaded,
//   and a stalled result holds the sequencer in its output step
// reset: synchronous; the tree comes back as one free root leaf at once, heap_base is 0
module buddy_heap_allocator_core import bha_pkg::*; #(
  parameter int MIN_ORDER = MIN_ORDER_DEF,
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [SIZE_W-1:0]    size,
  input  logic [ADDR_W-1:0]    address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic [ADDR_W-1:0]    block_address,
  output logic [SIZE_W-1:0]    freed_bytes
);

  localparam int LEVELS = MAX_ORDER - MIN_ORDER + 1;
  localparam int IDX_W = LEVELS;
  localparam int OFF_W = MAX_ORDER;
  localparam int SZ_W = SIZE_W + 1;
  localparam logic [ADDR_W-1:0] HEAP_BYTES = ADDR_W'(1) << MAX_ORDER;
  localparam logic [ORD_W-1:0] MIN_ORD = ORD_W'(MIN_ORDER);
  localparam logic [ORD_W-1:0] MAX_ORD = ORD_W'(MAX_ORDER);

  state_t               state, state_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic [ORD_W-1:0]     ord, ord_next;
  logic [ORD_W-1:0]     want, want_next;
  logic [OFF_W-1:0]     base, base_next;
  logic [OFF_W-1:0]     off, off_next;
  logic [SIZE_W-1:0]    req_size, req_size_next;
  status_t              pend_status, pend_status_next;
  logic [ADDR_W-1:0]    pend_addr, pend_addr_next;
  logic [SIZE_W-1:0]    pend_freed, pend_freed_next;
  logic [ADDR_W-1:0]    heap_base;

  logic [IDX_W-1:0]     child_l, child_r, parent, sibling;
  logic [OFF_W:0]       span, half;
  logic [ADDR_W-1:0]    diff;
  logic                 out_load;

  store_ctl_t           ctl;
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  node_t                rd_node, wr_node;
  logic [SIZE_W-1:0]    rd_size;

  assign child_l = IDX_W'({idx, 1'b1});
  assign child_r = child_l + IDX_W'(1);
  assign parent  = IDX_W'((idx - IDX_W'(1)) >> 1);
  assign sibling = idx[0] ? idx + IDX_W'(1) : idx - IDX_W'(1);
  assign span    = (OFF_W+1)'(1) << ord;
  assign half    = span >> 1;
  assign diff    = address - heap_base;
  assign rd_addr = (state == ST_CO_RD) ? sibling : idx;
  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  bha_node_store #(
    .MIN_ORDER(MIN_ORDER),
    .MAX_ORDER(MAX_ORDER)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_node (rd_node),
    .rd_size (rd_size),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .wr_node (wr_node),
    .wr_size (req_size),
    .clr_addr(child_l)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      heap_base <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        heap_base <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    ord         <= ord_next;
    want        <= want_next;
    base        <= base_next;
    off         <= off_next;
    req_size    <= req_size_next;
    pend_status <= pend_status_next;
    pend_addr   <= pend_addr_next;
    pend_freed  <= pend_freed_next;
    if (out_load) begin
      status        <= pend_status;
      block_address <= pend_addr;
      freed_bytes   <= pend_freed;
    end
  end

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    ord_next         = ord;
    want_next        = want;
    base_next        = base;
    off_next         = off;
    req_size_next    = req_size;
    pend_status_next = pend_status;
    pend_addr_next   = pend_addr;
    pend_freed_next  = pend_freed;
    ctl              = '0;
    wr_addr          = idx;
    wr_node          = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          idx_next         = '0;
          ord_next         = MAX_ORD;
          base_next        = '0;
          want_next        = MIN_ORD;
          req_size_next    = size;
          off_next         = OFF_W'(diff);
          pend_status_next = STATUS_INVALID;
          pend_addr_next   = '0;
          pend_freed_next  = '0;
          if (!op) begin
            if (size == '0 || ADDR_W'(size) > HEAP_BYTES) begin
              state_next = ST_OUT;
            end else begin
              state_next = ST_WANT;
            end
          end else begin
            if (diff >= HEAP_BYTES) begin
              state_next = ST_OUT;
            end else begin
              state_next = ST_F_RD;
            end
          end
        end
      end
      ST_WANT: begin
        if (((SZ_W'(1) << want) < SZ_W'(req_size)) && (want < MAX_ORD)) begin
          want_next = want + ORD_W'(1);
        end else begin
          state_next = ST_A_RD;
        end
      end
      ST_A_RD: begin
        state_next = ST_A_CHK;
      end
      ST_A_CHK: begin
        if (rd_node.alloc || ord < want) begin
          state_next = ST_A_UP;
        end else if (rd_node.split && ord > MIN_ORD) begin
          idx_next   = child_l;
          ord_next   = ord - ORD_W'(1);
          state_next = ST_A_RD;
        end else if (ord > want) begin
          state_next = ST_A_SPLIT;
        end else begin
          state_next = ST_A_MARK;
        end
      end
      ST_A_UP: begin
        if (idx == '0) begin
          pend_status_next = STATUS_NO_SPACE;
          state_next       = ST_OUT;
        end else if (idx[0]) begin
          idx_next   = child_l - child_l + idx + IDX_W'(1);
          base_next  = base + OFF_W'(span);
          state_next = ST_A_RD;
        end else begin
          idx_next  = parent;
          base_next = base - OFF_W'(span);
          ord_next  = ord + ORD_W'(1);
        end
      end
      ST_A_SPLIT: begin
        ctl.node_we   = 1'b1;
        ctl.clr_en    = 1'b1;
        wr_node.split = 1'b1;
        idx_next      = child_l;
        ord_next      = ord - ORD_W'(1);
        if (ord - ORD_W'(1) == want) begin
          state_next = ST_A_MARK;
        end
      end
      ST_A_MARK: begin
        ctl.node_we      = 1'b1;
        ctl.size_we      = 1'b1;
        wr_node.alloc    = 1'b1;
        pend_status_next = STATUS_OK;
        pend_addr_next   = heap_base + ADDR_W'(base);
        state_next       = ST_OUT;
      end
      ST_F_RD: begin
        state_next = ST_F_CHK;
      end
      ST_F_CHK: begin
        if (base == off && rd_node.alloc) begin
          ctl.node_we      = 1'b1;
          pend_status_next = STATUS_OK;
          pend_freed_next  = rd_size;
          state_next       = (idx == '0) ? ST_OUT : ST_CO_RD;
        end else if (!rd_node.split || ord <= MIN_ORD) begin
          pend_status_next = STATUS_NOT_FOUND;
          state_next       = ST_OUT;
        end else begin
          if ((OFF_W+1)'(off) >= (OFF_W+1)'(base) + half) begin
            idx_next  = child_r;
            base_next = base + OFF_W'(half);
          end else begin
            idx_next = child_l;
          end
          ord_next   = ord - ORD_W'(1);
          state_next = ST_F_RD;
        end
      end
      ST_CO_RD: begin
        state_next = ST_CO_CHK;
      end
      ST_CO_CHK: begin
        if (rd_node.alloc || rd_node.split) begin
          state_next = ST_OUT;
        end else begin
          ctl.node_we = 1'b1;
          wr_addr     = parent;
          idx_next    = parent;
          state_next  = (parent == '0) ? ST_OUT : ST_CO_RD;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a word while the sequencer was busy");

  a_clear_apart: assert property (@(posedge clk) disable iff (rst)
    (ctl.clr_en && ctl.node_we) |-> (wr_addr != child_l && wr_addr != child_r))
    else $error("node write collides with a child clear");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("result shown without the output step");
`endif

endmodule

>>> dv/bha_checker.sv
`timescale 1ns / 1ps
module bha_checker import bha_pkg::*; #(
  parameter int MIN_ORDER = MIN_ORDER_DEF,
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              op,
  input  logic [SIZE_W-1:0] size,
  input  logic [ADDR_W-1:0] address,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [STATUS_W-1:0] status,
  input  logic [ADDR_W-1:0] block_address,
  input  logic [SIZE_W-1:0] freed_bytes,
  output int                fail_count,
  output int                pending
);
  localparam int NODES = (1 << (MAX_ORDER - MIN_ORDER + 1)) - 1;
  localparam int HEAP = 1 << MAX_ORDER;

  typedef struct packed {
    status_t           st;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] bytes;
  } reply_t;

  logic [ADDR_W-1:0] base_reg;
  logic              is_split [NODES];
  logic              is_taken [NODES];
  logic [SIZE_W-1:0] req_bytes [NODES];
  reply_t            replies_due [$];

  function automatic int leftmost_leaf(int idx, int ord, int need, ref int got);
    int r;
    if (idx >= NODES || is_taken[idx] || ord < need) return -1;
    if (is_split[idx] && ord > MIN_ORDER) begin
      r = leftmost_leaf(2 * idx + 1, ord - 1, need, got);
      if (r >= 0) return r;
      return leftmost_leaf(2 * idx + 2, ord - 1, need, got);
    end
    got = ord;
    return idx;
  endfunction

  function automatic reply_t heap_step(logic is_free, logic [SIZE_W-1:0] sz,
                                       logic [ADDR_W-1:0] a);
    reply_t r;
    int need, ord, idx, blk_base, sib;
    logic [ADDR_W-1:0] off;
    r = '0;
    r.st = STATUS_OK;
    if (!is_free) begin
      if (sz == 0 || sz > HEAP) begin
        r.st = STATUS_INVALID;
        return r;
      end
      need = MIN_ORDER;
      while ((1 << need) < sz && need < MAX_ORDER) need++;
      ord = 0;
      idx = leftmost_leaf(0, MAX_ORDER, need, ord);
      if (idx < 0) begin
        r.st = STATUS_NO_SPACE;
        return r;
      end
      while (ord > need) begin
        is_split[idx] = 1'b1;
        is_split[2 * idx + 1] = 1'b0;
        is_taken[2 * idx + 1] = 1'b0;
        is_split[2 * idx + 2] = 1'b0;
        is_taken[2 * idx + 2] = 1'b0;
        idx = 2 * idx + 1;
        ord--;
      end
      is_taken[idx] = 1'b1;
      req_bytes[idx] = sz;
      off = ADDR_W'((idx - ((1 << (MAX_ORDER - ord)) - 1)) << ord);
      r.addr = base_reg + off;
      return r;
    end
    off = a - base_reg;
    if (off >= HEAP) begin
      r.st = STATUS_INVALID;
      return r;
    end
    idx = 0;
    ord = MAX_ORDER;
    blk_base = 0;
    forever begin
      if (blk_base == off && is_taken[idx]) break;
      if (!is_split[idx] || ord <= MIN_ORDER) break;
      if (off >= blk_base + (1 << (ord - 1))) begin
        idx = 2 * idx + 2;
        blk_base += 1 << (ord - 1);
      end else begin
        idx = 2 * idx + 1;
      end
      ord--;
    end
    if (blk_base != off || !is_taken[idx]) begin
      r.st = STATUS_NOT_FOUND;
      return r;
    end
    r.bytes = req_bytes[idx];
    is_taken[idx] = 1'b0;
    while (idx != 0) begin
      sib = (idx & 1) ? idx + 1 : idx - 1;
      if (is_taken[sib] || is_split[sib]) break;
      idx = (idx - 1) / 2;
      is_split[idx] = 1'b0;
      is_taken[idx] = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    int errs;
    errs = 0;
    if (rst) begin
      base_reg <= '0;
      for (int i = 0; i < NODES; i++) begin
        is_split[i] = 1'b0;
        is_taken[i] = 1'b0;
        req_bytes[i] = '0;
      end
      replies_due.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) base_reg <= cfg_data;
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("unexpected word: status %0d", status);
          errs++;
        end else begin
          want = replies_due.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            errs++;
          end
          if (block_address !== want.addr) begin
            $error("block_address: expected %h, got %h", want.addr, block_address);
            errs++;
          end
          if (freed_bytes !== want.bytes) begin
            $error("freed_bytes: expected %0d, got %0d", want.bytes, freed_bytes);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) replies_due.push_back(heap_step(op, size, address));
      fail_count <= fail_count + errs;
      pending <= replies_due.size();
    end
  end

endmodule

>>> dv/tb_buddy_heap_allocator_core.sv
`timescale 1ns / 1ps
module tb_buddy_heap_allocator_core;
  import bha_pkg::*;

  localparam int HEAP = 1 << MAX_ORDER_DEF;
  localparam longint CYCLE_LIMIT = 10000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [SIZE_W-1:0] size = '0;
  logic [ADDR_W-1:0] address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0] block_address;
  logic [SIZE_W-1:0] freed_bytes;
  int fail_count, pending;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 1'b0;
  event hold_start;
  longint cycles = 0;
  logic [ADDR_W-1:0] heap_base = '0;
  logic [ADDR_W-1:0] live_blocks [$];

  always #5 clk = ~clk;

  buddy_heap_allocator_core u_top (.*);

  bha_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stalls at random, or holds off for a long stretch
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    forever begin
      @(hold_start);
      hold_off = 1'b1;
      repeat (400) @(negedge clk);
      hold_off = 1'b0;
    end
  end

  // track addresses handed out, so frees mostly hit live blocks
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready && status == STATUS_OK && block_address != 0
        && live_blocks.size() < 64)
      live_blocks.push_back(block_address);
  end

  task automatic send_word(logic is_free, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a);
    do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    in_valid <= 1'b1;
    op <= is_free;
    size <= sz;
    address <= a;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic set_base(logic [ADDR_W-1:0] b);
    wait (pending == 0);
    repeat (300) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= b;
    heap_base = b;
    live_blocks.delete();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word();
    int k;
    int pick;
    k = $urandom_range(99);
    if (k < 45) begin
      pick = $urandom_range(9);
      send_word(1'b0, pick < 7 ? SIZE_W'($urandom_range(300, 1))
                    : pick < 9 ? SIZE_W'($urandom_range(HEAP, 1))
                    : SIZE_W'($urandom), $urandom);
    end else if (k < 85 && live_blocks.size() > 0) begin
      pick = $urandom_range(live_blocks.size() - 1);
      send_word(1'b1, SIZE_W'($urandom), live_blocks[pick]);
      live_blocks.delete(pick);
    end else if (k < 93) begin
      send_word(1'b1, SIZE_W'($urandom), heap_base + ($urandom_range(HEAP / 32 - 1) << 5));
    end else begin
      send_word(1'b1, SIZE_W'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_word(1'b0, 16'd0, '0);
    send_word(1'b0, 16'hFFFF, '1);
    send_word(1'b0, SIZE_W'(HEAP + 1), '0);
    send_word(1'b0, SIZE_W'(HEAP), '0);
    send_word(1'b0, 16'd1, '0);
    send_word(1'b1, 16'hFFFF, 32'd0);
    send_word(1'b1, '0, 32'd0);
    send_word(1'b0, 16'd1, '0);
    send_word(1'b0, 16'd32, '0);
    send_word(1'b0, 16'd33, '0);
    send_word(1'b0, 16'd2048, '0);
    send_word(1'b0, 16'd2047, '0);
    send_word(1'b1, '0, 32'd64);
    send_word(1'b1, '0, 32'd32);
    send_word(1'b1, '0, 32'd16);
    send_word(1'b1, '0, 32'hFFFF_FFFF);
    send_word(1'b1, '0, 32'd0);
    send_word(1'b1, '0, 32'd128);
    send_word(1'b1, '0, 32'd2048);
    for (int i = 0; i < 130; i++) send_word(1'b0, 16'd32, '0);
    for (int i = 0; i < 128; i++) send_word(1'b1, '0, ADDR_W'(i * 32));
    set_base(32'hFFFF_FFF0);
    send_word(1'b0, 16'd20, '0);
    send_word(1'b1, '0, 32'hFFFF_FFF0);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 22 : ph == 1 ? 88 : 0;
      recv_idle_pct = ph == 0 ? 88 : ph == 1 ? 22 : 0;
      case (ph)
        0: set_base($urandom);
        1: set_base(32'h0000_0000);
        default: set_base(32'hFFFF_FFFF);
      endcase
      for (int i = 0; i < 320; i++) begin
        if (ph == 2 && i == 50) -> hold_start;
        random_word();
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_base(32'h8000_1000);
    for (int i = 0; i < 500; i++) random_word();
    wait (pending == 0);
    repeat (300) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
